// ----- rtl/core/ffpa_pkg.sv -----
// Shared types and constants for the first-fit partition allocator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

  localparam int IDX_W = 5;
  localparam int SIZE_W = 16;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 6'd32;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 40;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REQ = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic take;
    logic publish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic more;
    logic pending;
    logic out_busy;
  } sts_t;

endpackage : ffpa_pkg

`default_nettype wire

// ----- rtl/core/ffpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : ffpa_ram

`default_nettype wire

// ----- rtl/core/ffpa_ctrl.sv -----
// Controller state machine of the allocator: input handshake and scan sequencing.
// Depends on ffpa_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_func_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_REQ) begin
            cmd_o.start = 1'b1;
            state_d = S_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.take = 1'b1;
          state_d = S_DONE;
        end else if (!sts_i.more && !sts_i.pending) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : ffpa_ctrl

`default_nettype wire

// ----- rtl/core/ffpa_datapath.sv -----
// Datapath of the allocator: size memory, used marks, scan counter, compare and output register.
// Depends on ffpa_pkg and ffpa_ram; commanded by ffpa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ffpa_datapath
  import ffpa_pkg::*;
#(
  parameter int MAX_BLOCKS = 32,
  parameter int SIZE_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_wr_en_i,
  input  wire logic [CNT_W-1:0]  cfg_wr_data_i,
  input  wire logic [IDX_W-1:0]  in_index_i,
  input  wire logic [SIZE_W-1:0] in_size_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   out_granted_o,
  output logic [IDX_W-1:0]       out_block_o,
  output logic [SIZE_W-1:0]      out_size_o,
  output logic [SIZE_W-1:0]      out_left_o
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam int LW = (CW > CNT_W) ? CW : CNT_W;
  localparam int EW = SIZE_BITS + SIZE_W;

  logic [CNT_W-1:0]     cnt_q;
  logic [CW-1:0]        lim_q, k_q;
  logic [SIZE_BITS-1:0] req_q;
  logic                 cmp_valid_q, cmp_used_q;
  logic [AW-1:0]        cmp_idx_q;
  logic [MAX_BLOCKS-1:0] used_q;

  logic                 res_granted_q;
  logic [AW-1:0]        res_idx_q;
  logic [SIZE_BITS-1:0] res_size_q, res_left_q;

  logic                 out_valid_q, out_granted_q;
  logic [IDX_W-1:0]     out_block_q;
  logic [SIZE_W-1:0]    out_size_q, out_left_q;

  logic [XW-1:0]        in_idx_ext;
  logic [AW-1:0]        in_addr;
  logic                 in_idx_ok;
  logic [EW-1:0]        in_size_ext;
  logic [SIZE_BITS-1:0] in_sz;
  logic [LW-1:0]        lim_ext;
  logic [AW-1:0]        scan_addr;
  logic                 issue;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 hit;
  logic [XW-1:0]        res_idx_ext;
  logic [EW-1:0]        res_size_ext, res_left_ext;

  assign in_idx_ext = XW'(in_index_i);
  assign in_addr = in_idx_ext[AW-1:0];
  assign in_idx_ok = (32'(in_index_i) < MAX_BLOCKS);
  assign in_size_ext = {{SIZE_BITS{1'b0}}, in_size_i};
  assign in_sz = in_size_ext[SIZE_BITS-1:0];

  // saturate the partition count to the table depth
  assign lim_ext = (LW'(cnt_q) > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : LW'(cnt_q);

  assign scan_addr = k_q[AW-1:0];
  assign issue = cmd_i.scan && (k_q < lim_q);

  ffpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && in_idx_ok),
    .waddr_i (in_addr),
    .wdata_i (in_sz),
    .re_i    (issue),
    .raddr_i (scan_addr),
    .rdata_o (rd_data)
  );

  assign hit = cmp_valid_q && !cmp_used_q && (rd_data >= req_q);

  assign sts_o.hit = hit;
  assign sts_o.more = (k_q < lim_q);
  assign sts_o.pending = cmp_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= BLOCK_COUNT_RESET;
      used_q <= '0;
      cmp_valid_q <= 1'b0;
      k_q <= '0;
      lim_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        cnt_q <= cfg_wr_data_i;
      end
      if (cmd_i.load && in_idx_ok) begin
        used_q[in_addr] <= 1'b0;
      end
      if (cmd_i.take) begin
        used_q[cmp_idx_q] <= 1'b1;
      end
      if (cmd_i.start) begin
        k_q <= '0;
        lim_q <= lim_ext[CW-1:0];
      end else if (issue) begin
        k_q <= k_q + 1'b1;
      end
      cmp_valid_q <= issue;
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_idx_q <= scan_addr;
      cmp_used_q <= used_q[scan_addr];
    end
    if (cmd_i.start) begin
      req_q <= in_sz;
      res_granted_q <= 1'b0;
      res_idx_q <= '0;
      res_size_q <= '0;
      res_left_q <= '0;
    end else if (cmd_i.take) begin
      res_granted_q <= 1'b1;
      res_idx_q <= cmp_idx_q;
      res_size_q <= rd_data;
      res_left_q <= rd_data - req_q;
    end
    if (cmd_i.publish) begin
      out_granted_q <= res_granted_q;
      out_block_q <= res_idx_ext[IDX_W-1:0];
      out_size_q <= res_size_ext[SIZE_W-1:0];
      out_left_q <= res_left_ext[SIZE_W-1:0];
    end
  end

  assign res_idx_ext = XW'(res_idx_q);
  assign res_size_ext = {{SIZE_W{1'b0}}, res_size_q};
  assign res_left_ext = {{SIZE_W{1'b0}}, res_left_q};

  assign out_valid_o = out_valid_q;
  assign out_granted_o = out_granted_q;
  assign out_block_o = out_block_q;
  assign out_size_o = out_size_q;
  assign out_left_o = out_left_q;

  a_take_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |=> used_q[$past(cmp_idx_q)])
    else $error("taken partition not marked used");

  a_publish_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while stalled");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= lim_q)
    else $error("scan counter past limit");

  a_take_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |-> (cmp_valid_q && !cmp_used_q))
    else $error("grant of a used or stale partition");

endmodule : ffpa_datapath

`default_nettype wire

// ----- rtl/core/first_fit_partition_allocator_top.sv -----
// Top level of the first-fit fixed-partition allocator.
// Depends on ffpa_pkg, ffpa_ctrl, ffpa_datapath and ffpa_ram.
//
// Input stream: tuser carries func (0 load, 1 request); tdata carries the partition index
// and the size. A load writes that partition's size and frees it and gives no item on the
// output. A request scans partitions from index 0 up to one below the configured count
// (saturated to the table depth), one per cycle through the size memory read port, and
// takes the first free one that is large enough.
// Output stream: one item per request; tuser is granted, tdata holds index, size and
// leftover, all zero when nothing fits.
// A request keeps the block busy until its result is published, ending its scan early on a
// hit; the input is not ready meanwhile. The result sits in an output register, so loads
// keep flowing while it waits; a further request finishes its scan and then holds until
// the receiver takes the earlier result. Reset: all partitions free, count set to 32,
// sizes undefined until loaded. Configuration: cfg_wr_en_i writes the partition count;
// the user must write it only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_partition_allocator_top
  import ffpa_pkg::*;
#(
  parameter int MAX_BLOCKS = 32,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_wr_en_i,
  input  wire logic [CNT_W-1:0]    cfg_wr_data_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [S_DATA_W-1:0] s_axis_tdata_i,  // block_index, size, zero pad
  input  wire logic                s_axis_tuser_i,  // func
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0]      m_axis_tdata_o,  // chosen_block, chosen_size, leftover, pad
  output logic                     m_axis_tuser_o   // granted
);

  cmd_t              cmd;
  sts_t              sts;
  logic [IDX_W-1:0]  out_block;
  logic [SIZE_W-1:0] out_size, out_left;

  ffpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_index_i    (s_axis_tdata_i[IDX_W-1:0]),
    .in_size_i     (s_axis_tdata_i[IDX_W+SIZE_W-1:IDX_W]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_granted_o (m_axis_tuser_o),
    .out_block_o   (out_block),
    .out_size_o    (out_size),
    .out_left_o    (out_left)
  );

  assign m_axis_tdata_o = {(M_DATA_W - IDX_W - 2 * SIZE_W)'(0), out_left, out_size, out_block};

endmodule : first_fit_partition_allocator_top

`default_nettype wire
